FILE: design/scpc_pkg.sv
// ----------------------------------------------------------------------------
// scpc_pkg
// Shared types and constants of the step cadence pace classifier: pace and
// status codes, configuration register indexes and fixed arithmetic limits.
// ----------------------------------------------------------------------------
package scpc_pkg;

    // Pace codes
    typedef enum logic [1:0] {
        PACE_STAND = 2'd0,
        PACE_WALK  = 2'd1,
        PACE_RUN   = 2'd2
    } pace_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_FIRST      = 3'd0,
        ST_SHORT      = 3'd1,
        ST_LONG_GAP   = 3'd2,
        ST_SLOW       = 3'd3,
        ST_WAIT       = 3'd4,
        ST_CLASSIFIED = 3'd5,
        ST_TIMEOUT    = 3'd6,
        ST_IDLE       = 3'd7
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_SPM,
        S_CHECK,
        S_MEAN,
        S_DIV_AVG,
        S_DIV_RUN,
        S_OUT
    } seq_state_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_STEP      = 3'd0;
    localparam logic [2:0] CFG_MAX_TRACKED   = 3'd1;
    localparam logic [2:0] CFG_WALK_SPM_MIN  = 3'd2;
    localparam logic [2:0] CFG_WALK_CONFIRM  = 3'd3;
    localparam logic [2:0] CFG_RUN_SPM_MIN   = 3'd4;
    localparam logic [2:0] CFG_RUN_CONFIRM   = 3'd5;
    localparam logic [2:0] CFG_STAND_TIMEOUT = 3'd6;

    // Milliseconds per minute, numerator of every rate divide
    localparam logic [15:0] SPM_SCALE = 16'd60000;
    // Candidate counters stop here
    localparam logic [7:0]  CNT_MAX   = 8'd255;

endpackage

FILE: design/scpc_req_if.sv
// ----------------------------------------------------------------------------
// scpc_req_if
// Request channel: one step event or idle timeout check with its timestamp.
// ----------------------------------------------------------------------------
interface scpc_req_if;

    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] time_ms;

    modport source (output valid, output operation, output time_ms, input ready);
    modport sink   (input valid, input operation, input time_ms, output ready);

endinterface

FILE: design/scpc_rsp_if.sv
// ----------------------------------------------------------------------------
// scpc_rsp_if
// Result channel: pace classification and diagnostics for one request.
// ----------------------------------------------------------------------------
interface scpc_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  stable_pace;
    logic [1:0]  current_pace;
    logic [2:0]  status;
    logic [15:0] avg_interval_ms;
    logic [15:0] instant_spm;

    modport source (
        output valid, output stable_pace, output current_pace, output status,
        output avg_interval_ms, output instant_spm, input ready
    );
    modport sink (
        input valid, input stable_pace, input current_pace, input status,
        input avg_interval_ms, input instant_spm, output ready
    );

endinterface

FILE: design/step_cadence_pace_classifier.sv
// ----------------------------------------------------------------------------
// step_cadence_pace_classifier
// Classifies gait from timestamped step events and idle checks, keeping a
// ring of recent step intervals and a running sum for the mean.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid/ready   | operation, time_ms
//  rsp     | out | valid/ready   | stable_pace, current_pace, status,
//          |     |               | avg_interval_ms, instant_spm
//  cfg     | in  | cfg_we only   | cfg_index, cfg_data
//
//  A request that ends early (idle check, first step, short, long gap) goes
//  from the evaluate state straight to the output state; a full
//  classification runs rate, mean and average-rate divides one after another
//  on the shared serial divider, which is SW = 16 + clog2(WINDOW) bits wide.
//  req.ready is high only while the sequencer is idle; a result waiting on
//  rsp does not block the next request until its own result is due.
//  Reset clears all control state and restores the register defaults; no
//  clearing pass is needed since the ring is qualified by its fill count.
// ----------------------------------------------------------------------------
module step_cadence_pace_classifier
    import scpc_pkg::*;
#(
    parameter int unsigned WINDOW = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    scpc_req_if.sink    req,
    scpc_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned FW = $clog2(WINDOW + 1);
    localparam int unsigned SW = 16 + $clog2(WINDOW);

    // Configuration registers
    logic [15:0] cfg_min_step_reg;
    logic [15:0] cfg_max_tracked_reg;
    logic [15:0] cfg_walk_spm_min_reg;
    logic [7:0]  cfg_walk_confirm_reg;
    logic [15:0] cfg_run_spm_min_reg;
    logic [7:0]  cfg_run_confirm_reg;
    logic [31:0] cfg_timeout_reg;

    // Sequencer and tracking state
    seq_state_t  state_reg, state_next;
    logic        op_reg, op_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] iv_reg, iv_next;
    logic [31:0] last_reg, last_next;
    logic [HW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [7:0]  wc_reg, wc_next;
    logic [7:0]  rc_reg, rc_next;
    pace_t       raw_reg, raw_next;
    pace_t       conf_reg, conf_next;
    logic [15:0] inst_reg, inst_next;
    status_t     res_status_reg, res_status_next;
    logic [15:0] res_spm_reg, res_spm_next;
    logic [15:0] res_avg_reg, res_avg_next;

    // Output register
    logic        rsp_valid_reg, rsp_valid_next;
    pace_t       out_stable_reg, out_stable_next;
    pace_t       out_current_reg, out_current_next;
    status_t     out_status_reg, out_status_next;
    logic [15:0] out_avg_reg, out_avg_next;
    logic [15:0] out_spm_reg, out_spm_next;

    // Interval ring
    logic [15:0] ring_mem [WINDOW];
    logic [15:0] rd_reg;
    logic        ring_we;
    logic [SW-1:0] old_iv;
    logic [7:0]  wc_inc;
    logic [7:0]  rc_inc;

    // Shared divider
    logic          div_start;
    logic [SW-1:0] div_dividend;
    logic [15:0]   div_divisor;
    logic          div_done;
    logic [SW-1:0] div_quot;

    scpc_div #(
        .DW (SW)
    ) u_scpc_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_min_step_reg     <= 16'd200;
            cfg_max_tracked_reg  <= 16'd2000;
            cfg_walk_spm_min_reg <= 16'd50;
            cfg_walk_confirm_reg <= 8'd4;
            cfg_run_spm_min_reg  <= 16'd140;
            cfg_run_confirm_reg  <= 8'd3;
            cfg_timeout_reg      <= 32'd2000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_STEP:      cfg_min_step_reg     <= cfg_data[15:0];
                CFG_MAX_TRACKED:   cfg_max_tracked_reg  <= cfg_data[15:0];
                CFG_WALK_SPM_MIN:  cfg_walk_spm_min_reg <= cfg_data[15:0];
                CFG_WALK_CONFIRM:  cfg_walk_confirm_reg <= cfg_data[7:0];
                CFG_RUN_SPM_MIN:   cfg_run_spm_min_reg  <= cfg_data[15:0];
                CFG_RUN_CONFIRM:   cfg_run_confirm_reg  <= cfg_data[7:0];
                CFG_STAND_TIMEOUT: cfg_timeout_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Oldest entry drops out of the sum only once the ring is full
    assign old_iv = (fill_reg == FW'(WINDOW)) ? SW'(rd_reg) : '0;
    assign wc_inc = (wc_reg == CNT_MAX) ? wc_reg : wc_reg + 8'd1;
    assign rc_inc = (rc_reg == CNT_MAX) ? rc_reg : rc_reg + 8'd1;

    // Sequencer: next state, tracking updates and divider requests
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        now_next         = now_reg;
        iv_next          = iv_reg;
        last_next        = last_reg;
        head_next        = head_reg;
        fill_next        = fill_reg;
        sum_next         = sum_reg;
        wc_next          = wc_reg;
        rc_next          = rc_reg;
        raw_next         = raw_reg;
        conf_next        = conf_reg;
        inst_next        = inst_reg;
        res_status_next  = res_status_reg;
        res_spm_next     = res_spm_reg;
        res_avg_next     = res_avg_reg;
        rsp_valid_next   = rsp_valid_reg;
        out_stable_next  = out_stable_reg;
        out_current_next = out_current_reg;
        out_status_next  = out_status_reg;
        out_avg_next     = out_avg_reg;
        out_spm_next     = out_spm_reg;
        ring_we          = 1'b0;
        div_start        = 1'b0;
        div_dividend     = SW'(SPM_SCALE);
        div_divisor      = iv_reg[15:0];

        // Drop the held result once taken
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.operation;
                    now_next   = req.time_ms;
                    iv_next    = req.time_ms - last_reg;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                res_spm_next = '0;
                res_avg_next = '0;
                state_next   = S_OUT;
                priority if (op_reg)
                begin
                    res_status_next = ST_IDLE;
                    if ((last_reg != '0) && (iv_reg > cfg_timeout_reg))
                    begin
                        head_next       = '0;
                        fill_next       = '0;
                        sum_next        = '0;
                        last_next       = '0;
                        wc_next         = '0;
                        rc_next         = '0;
                        raw_next        = PACE_STAND;
                        conf_next       = PACE_STAND;
                        res_status_next = ST_TIMEOUT;
                    end
                end
                else if (last_reg == '0)
                begin
                    last_next       = now_reg;
                    head_next       = '0;
                    fill_next       = '0;
                    sum_next        = '0;
                    wc_next         = 8'd1;
                    rc_next         = '0;
                    raw_next        = PACE_STAND;
                    conf_next       = PACE_STAND;
                    res_status_next = ST_FIRST;
                end
                else if (iv_reg < {16'd0, cfg_min_step_reg})
                begin
                    res_status_next = ST_SHORT;
                end
                else
                begin
                    last_next = now_reg;
                    priority if (iv_reg > {16'd0, cfg_max_tracked_reg})
                    begin
                        head_next       = '0;
                        fill_next       = '0;
                        sum_next        = '0;
                        wc_next         = 8'd1;
                        rc_next         = '0;
                        raw_next        = PACE_STAND;
                        conf_next       = PACE_STAND;
                        res_status_next = ST_LONG_GAP;
                    end
                    else if (iv_reg[15:0] == 16'd0)
                    begin
                        // Zero interval saturates the rate
                        inst_next  = SPM_SCALE;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV_SPM;
                    end
                end
            end

            S_DIV_SPM:
            begin
                if (div_done)
                begin
                    inst_next  = div_quot[15:0];
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                res_spm_next = inst_reg;
                if (inst_reg < cfg_walk_spm_min_reg)
                begin
                    head_next       = '0;
                    fill_next       = '0;
                    sum_next        = '0;
                    wc_next         = 8'd1;
                    rc_next         = '0;
                    raw_next        = PACE_STAND;
                    conf_next       = PACE_STAND;
                    res_status_next = ST_SLOW;
                    state_next      = S_OUT;
                end
                else
                begin
                    // Push the interval and advance the ring
                    ring_we   = 1'b1;
                    sum_next  = sum_reg - old_iv + SW'(iv_reg[15:0]);
                    head_next = (head_reg == HW'(WINDOW - 1)) ? '0 : head_reg + HW'(1);
                    if (fill_reg != FW'(WINDOW))
                    begin
                        fill_next = fill_reg + FW'(1);
                    end
                    wc_next = wc_inc;
                    if (wc_inc < cfg_walk_confirm_reg)
                    begin
                        raw_next        = PACE_STAND;
                        conf_next       = PACE_STAND;
                        res_status_next = ST_WAIT;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MEAN;
                    end
                end
            end

            S_MEAN:
            begin
                div_start    = 1'b1;
                div_dividend = sum_reg;
                div_divisor  = 16'(fill_reg);
                state_next   = S_DIV_AVG;
            end

            S_DIV_AVG:
            begin
                if (div_done)
                begin
                    res_avg_next    = div_quot[15:0];
                    res_status_next = ST_CLASSIFIED;
                    if (div_quot[15:0] == 16'd0)
                    begin
                        raw_next   = PACE_WALK;
                        conf_next  = PACE_WALK;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_start   = 1'b1;
                        div_divisor = div_quot[15:0];
                        state_next  = S_DIV_RUN;
                    end
                end
            end

            S_DIV_RUN:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                    if (div_quot >= SW'(cfg_run_spm_min_reg))
                    begin
                        raw_next  = PACE_RUN;
                        rc_next   = rc_inc;
                        conf_next = (rc_inc >= cfg_run_confirm_reg) ? PACE_RUN : PACE_WALK;
                    end
                    else
                    begin
                        rc_next   = '0;
                        raw_next  = PACE_WALK;
                        conf_next = PACE_WALK;
                    end
                end
            end

            S_OUT:
            begin
                // Load the result once the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    out_stable_next  = conf_reg;
                    out_current_next = raw_reg;
                    out_status_next  = res_status_reg;
                    out_avg_next     = res_avg_reg;
                    out_spm_next     = res_spm_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            wc_reg        <= '0;
            rc_reg        <= '0;
            raw_reg       <= PACE_STAND;
            conf_reg      <= PACE_STAND;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            wc_reg        <= wc_next;
            rc_reg        <= rc_next;
            raw_reg       <= raw_next;
            conf_reg      <= conf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        now_reg         <= now_next;
        iv_reg          <= iv_next;
        inst_reg        <= inst_next;
        res_status_reg  <= res_status_next;
        res_spm_reg     <= res_spm_next;
        res_avg_reg     <= res_avg_next;
        out_stable_reg  <= out_stable_next;
        out_current_reg <= out_current_next;
        out_status_reg  <= out_status_next;
        out_avg_reg     <= out_avg_next;
        out_spm_reg     <= out_spm_next;
    end

    // Ring memory: write at head, registered read of the entry at head
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[head_reg] <= iv_reg[15:0];
        end
        rd_reg <= ring_mem[head_reg];
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.stable_pace     = out_stable_reg;
    assign rsp.current_pace    = out_current_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.avg_interval_ms = out_avg_reg;
    assign rsp.instant_spm     = out_spm_reg;

endmodule

FILE: design/scpc_div.sv
// ----------------------------------------------------------------------------
// scpc_div
// Shared restoring divider: one quotient bit per cycle, DW quotient bits per
// divide, done pulses for one cycle when the quotient is ready. Divisor must be
// nonzero.
// ----------------------------------------------------------------------------
module scpc_div #(
    parameter int unsigned DW = 19
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [15:0]   divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [15:0]   dsr_reg, dsr_next;
    logic [15:0]   rem_reg, rem_next;
    logic [16:0]   shifted;
    logic [16:0]   diff;
    logic          ge;

    // Trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, dvd_reg[DW-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[15:0] : shifted[15:0];
            dvd_next = {dvd_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

FILE: design/scpc_checker.sv
// ----------------------------------------------------------------------------
// scpc_checker
// Port-level checks on the result channel of the pace classifier, attached
// to the top level by a bind.
// ----------------------------------------------------------------------------
module scpc_checker
    import scpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  stable_pace,
    input logic [1:0]  current_pace,
    input logic [2:0]  status,
    input logic [15:0] avg_interval_ms,
    input logic [15:0] instant_spm
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(stable_pace) && $stable(avg_interval_ms))
        else $error("result changed while stalled");

    // A mean is reported only for a classified step
    a_avg_only_classified: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (avg_interval_ms != 16'd0) |-> (status == ST_CLASSIFIED))
        else $error("mean reported without classification");

    // A rate is reported only once the interval was in range
    a_spm_statuses: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (instant_spm != 16'd0) |->
            (status == ST_SLOW) || (status == ST_WAIT) || (status == ST_CLASSIFIED))
        else $error("rate reported for a step without a tracked interval");

    // Waiting for confirmation reports standing on both paces
    a_wait_standing: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_WAIT) |->
            (stable_pace == PACE_STAND) && (current_pace == PACE_STAND))
        else $error("pace not standing while waiting for confirmation");

    // Confirmed running implies raw running
    a_run_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (stable_pace == PACE_RUN) |-> (current_pace == PACE_RUN))
        else $error("confirmed running without raw running");

endmodule

bind step_cadence_pace_classifier scpc_checker u_scpc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .stable_pace     (rsp.stable_pace),
    .current_pace    (rsp.current_pace),
    .status          (rsp.status),
    .avg_interval_ms (rsp.avg_interval_ms),
    .instant_spm     (rsp.instant_spm)
);
